### rtl/ctsc_pkg.sv
package ctsc_pkg;

  // lexer states
  typedef enum logic [2:0] {
    LEX_PLAIN  = 3'd0,
    LEX_LINE   = 3'd1,
    LEX_BLOCK  = 3'd2,
    LEX_STRING = 3'd3,
    LEX_ESCAPE = 3'd4,
    LEX_SLASH  = 3'd5
  } lex_state_e;

  // highlight styles
  typedef enum logic [1:0] {
    STY_PLAIN   = 2'd0,
    STY_COMMENT = 2'd1,
    STY_STRING  = 2'd2,
    STY_NUMBER  = 2'd3
  } style_e;

  // language modes
  localparam logic MODE_C      = 1'b0;
  localparam logic MODE_PYTHON = 1'b1;

  // character codes
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;

  // result queue geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  // one result
  typedef struct packed {
    logic [1:0] style;
    logic       last_in_run;
    logic       text_done;
  } res_t;

  // what one byte produces
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } lex_out_t;

endpackage

### rtl/ctsc_if.sv
interface ctsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       text_end;

  modport source (output valid, output char_byte, output text_end, input ready);
  modport sink   (input valid, input char_byte, input text_end, output ready);
endinterface

interface ctsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] style;
  logic       last_in_run;
  logic       text_done;

  modport source (output valid, output style, output last_in_run, output text_done,
                  input ready);
  modport sink   (input valid, input style, input last_in_run, input text_done,
                  output ready);
endinterface

### rtl/ctsc_lexer.sv
module ctsc_lexer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                mode_i,
  input  logic [7:0]          char_i,
  input  logic                last_i,
  output ctsc_pkg::lex_out_t  out_o
);

  ctsc_pkg::lex_state_e state_q, state_d;
  logic                 star_q, star_d;
  logic                 quote_q, quote_d;

  // plain-text classification of the current byte
  ctsc_pkg::lex_state_e pb_state;
  logic [1:0]           pb_style;
  logic                 pb_none;
  logic                 pb_quote_we;
  logic                 pb_quote;
  logic                 is_digit;
  logic [7:0]           close_ch;
  logic [1:0]           sty0, sty1;
  logic [1:0]           cnt;

  assign is_digit = (char_i >= ctsc_pkg::CH_ZERO) && (char_i <= ctsc_pkg::CH_NINE);

  always_comb begin
    pb_state    = ctsc_pkg::LEX_PLAIN;
    pb_style    = is_digit ? ctsc_pkg::STY_NUMBER : ctsc_pkg::STY_PLAIN;
    pb_none     = 1'b0;
    pb_quote_we = 1'b0;
    pb_quote    = 1'b0;
    if (mode_i == ctsc_pkg::MODE_PYTHON) begin
      if (char_i == ctsc_pkg::CH_HASH) begin
        pb_state = ctsc_pkg::LEX_LINE;
        pb_style = ctsc_pkg::STY_COMMENT;
      end else if (char_i == ctsc_pkg::CH_DQUOTE || char_i == ctsc_pkg::CH_SQUOTE) begin
        pb_state    = ctsc_pkg::LEX_STRING;
        pb_style    = ctsc_pkg::STY_STRING;
        pb_quote_we = 1'b1;
        pb_quote    = (char_i == ctsc_pkg::CH_SQUOTE);
      end
    end else begin
      if (char_i == ctsc_pkg::CH_SLASH && !last_i) begin
        pb_state = ctsc_pkg::LEX_SLASH;
        pb_none  = 1'b1;
      end else if (char_i == ctsc_pkg::CH_DQUOTE) begin
        pb_state    = ctsc_pkg::LEX_STRING;
        pb_style    = ctsc_pkg::STY_STRING;
        pb_quote_we = 1'b1;
        pb_quote    = 1'b0;
      end
    end
  end

  // closing quote of an open string
  assign close_ch = (mode_i == ctsc_pkg::MODE_PYTHON && quote_q) ? ctsc_pkg::CH_SQUOTE
                                                                 : ctsc_pkg::CH_DQUOTE;

  // next state and styles for this byte
  always_comb begin
    state_d = state_q;
    star_d  = star_q;
    quote_d = quote_q;
    cnt     = 2'd0;
    sty0    = ctsc_pkg::STY_PLAIN;
    sty1    = ctsc_pkg::STY_PLAIN;
    case (state_q)
      ctsc_pkg::LEX_LINE: begin
        cnt  = 2'd1;
        sty0 = ctsc_pkg::STY_COMMENT;
        if (char_i == ctsc_pkg::CH_NEWLINE) state_d = ctsc_pkg::LEX_PLAIN;
      end
      ctsc_pkg::LEX_BLOCK: begin
        cnt  = 2'd1;
        sty0 = ctsc_pkg::STY_COMMENT;
        if (mode_i == ctsc_pkg::MODE_PYTHON) begin
          if (char_i == ctsc_pkg::CH_NEWLINE) state_d = ctsc_pkg::LEX_PLAIN;
          star_d = 1'b0;
        end else if (star_q && char_i == ctsc_pkg::CH_SLASH) begin
          state_d = ctsc_pkg::LEX_PLAIN;
          star_d  = 1'b0;
        end else begin
          star_d = (char_i == ctsc_pkg::CH_STAR);
        end
      end
      ctsc_pkg::LEX_STRING: begin
        cnt  = 2'd1;
        sty0 = ctsc_pkg::STY_STRING;
        if (char_i == ctsc_pkg::CH_BACKSLASH && !last_i) state_d = ctsc_pkg::LEX_ESCAPE;
        else if (char_i == close_ch) state_d = ctsc_pkg::LEX_PLAIN;
      end
      ctsc_pkg::LEX_ESCAPE: begin
        cnt     = 2'd1;
        sty0    = ctsc_pkg::STY_STRING;
        state_d = ctsc_pkg::LEX_STRING;
      end
      ctsc_pkg::LEX_SLASH: begin
        if (mode_i == ctsc_pkg::MODE_C &&
            (char_i == ctsc_pkg::CH_SLASH || char_i == ctsc_pkg::CH_STAR)) begin
          // held slash opens a comment
          cnt     = 2'd2;
          sty0    = ctsc_pkg::STY_COMMENT;
          sty1    = ctsc_pkg::STY_COMMENT;
          state_d = (char_i == ctsc_pkg::CH_SLASH) ? ctsc_pkg::LEX_LINE
                                                   : ctsc_pkg::LEX_BLOCK;
          star_d  = 1'b0;
        end else begin
          // flush held slash, then treat byte as plain text
          cnt     = pb_none ? 2'd1 : 2'd2;
          sty0    = ctsc_pkg::STY_PLAIN;
          sty1    = pb_style;
          state_d = pb_state;
          if (pb_quote_we) quote_d = pb_quote;
        end
      end
      default: begin
        cnt     = pb_none ? 2'd0 : 2'd1;
        sty0    = pb_style;
        state_d = pb_state;
        if (pb_quote_we) quote_d = pb_quote;
      end
    endcase
    if (last_i) begin
      state_d = ctsc_pkg::LEX_PLAIN;
      star_d  = 1'b0;
      quote_d = 1'b0;
    end
  end

  // results handed to the queue
  always_comb begin
    out_o.count          = cnt;
    out_o.r0.style       = sty0;
    out_o.r0.last_in_run = (cnt == 2'd1);
    out_o.r0.text_done   = (cnt == 2'd1) && last_i;
    out_o.r1.style       = sty1;
    out_o.r1.last_in_run = 1'b1;
    out_o.r1.text_done   = last_i;
  end

  // lexer state, advanced per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctsc_pkg::LEX_PLAIN;
      star_q  <= 1'b0;
      quote_q <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      star_q  <= star_d;
      quote_q <= quote_d;
    end
  end

endmodule

### rtl/ctsc_res_fifo.sv
module ctsc_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ctsc_pkg::lex_out_t push_data_i,
  output logic               room_o,
  input  logic               pop_i,
  output logic               valid_o,
  output ctsc_pkg::res_t     head_o
);

  ctsc_pkg::res_t                  mem_q [ctsc_pkg::FifoDepth];
  logic [ctsc_pkg::PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [ctsc_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic [1:0]                      push_n;
  logic                            pop;
  logic [ctsc_pkg::PtrW-1:0]       wr_ptr_nx;

  assign push_n    = push_i ? push_data_i.count : 2'd0;
  assign pop       = pop_i && valid_o;
  assign valid_o   = (cnt_q != '0);
  assign head_o    = mem_q[rd_ptr_q];
  // room for the two results one byte can cause
  assign room_o    = (cnt_q <= ctsc_pkg::CntW'(ctsc_pkg::FifoDepth - 2));
  assign wr_ptr_nx = wr_ptr_q + ctsc_pkg::PtrW'(1);
  assign cnt_d     = cnt_q + ctsc_pkg::CntW'(push_n) - ctsc_pkg::CntW'(pop);

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) mem_q[wr_ptr_q]  <= push_data_i.r0;
    if (push_n == 2'd2) mem_q[wr_ptr_nx] <= push_data_i.r1;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ctsc_pkg::PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + ctsc_pkg::PtrW'(pop);
      cnt_q    <= cnt_d;
    end
  end

endmodule

### rtl/code_text_style_classifier.sv
// Source-text style classifier.
// in_i carries one text byte per transaction (char_byte, text_end marks the
// final byte of a text). out_o carries one style per transaction: style,
// last_in_run on the final style a byte causes, text_done on the final style
// of a text. A byte yields zero, one or two styles: a slash in C-like mode is
// held until the next byte, which then releases both styles together.
// cfg_we_i/cfg_wdata_i write language_mode (0 C-like, 1 Python); write it
// only while no transaction is in flight.
// A style enters the result queue when its byte is accepted and reaches
// out_o once the results ahead of it are taken. Throughput: one byte per
// cycle while the queue has room for two; the lexer state is registered
// and a four-entry result queue sits between lexer and output. A byte that
// yields two styles takes two entries and backs up into in_i.ready when the
// queue cannot take two more results. When out_o is stalled, results wait
// in the queue; in_i.ready drops once fewer than two entries are free.
// Reset empties the queue, clears the lexer to plain text and sets C-like mode.
module code_text_style_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  ctsc_in_if.sink    in_i,
  ctsc_out_if.source out_o
);

  logic               mode_q;
  logic               accept;
  logic               room;
  ctsc_pkg::lex_out_t lex_out;
  ctsc_pkg::res_t     head;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  // language mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ctsc_pkg::MODE_C;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // byte classification
  ctsc_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .mode_i (mode_q),
    .char_i (in_i.char_byte),
    .last_i (in_i.text_end),
    .out_o  (lex_out)
  );

  // result queue
  ctsc_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (lex_out),
    .room_o      (room),
    .pop_i       (out_o.ready),
    .valid_o     (out_o.valid),
    .head_o      (head)
  );

  assign out_o.style       = head.style;
  assign out_o.last_in_run = head.last_in_run;
  assign out_o.text_done   = head.text_done;

endmodule

### rtl/ctsc_checker.sv
module ctsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_style_i,
  input logic       out_last_i,
  input logic       out_done_i
);

  // nothing comes out while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // the end of a text is always the last style of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_done_i |-> out_last_i)
    else $error("text_done without last_in_run");

  // the first of a pair is followed at once by its partner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("second style of a byte missing");

  // stalled output holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_style_i) &&
    $stable(out_last_i) && $stable(out_done_i))
    else $error("stalled output changed");

endmodule

bind code_text_style_classifier ctsc_checker u_ctsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_style_i (out_o.style),
  .out_last_i  (out_o.last_in_run),
  .out_done_i  (out_o.text_done)
);
